>>> rtl/core/mlas_pkg.sv
package mlas_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_INTERIM = 2'd1,
        MODE_BUZZ    = 2'd2,
        MODE_WAIT    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_LIGHT_JUMP  = 3'd0,
        CFG_ACCEL_LIMIT = 3'd1,
        CFG_GYRO_LIMIT  = 3'd2,
        CFG_BUZZ_TICKS  = 3'd3,
        CFG_WAIT_TICKS  = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int JUMP_W      = 18;
    localparam int LIMIT_W     = 16;
    localparam int TICK_W      = 8;
    localparam int LIMIT_SQ_W  = 2 * (LIMIT_W + 1);
    localparam int LUX_DIV     = 100;
    localparam int OUT_TDATA_W = 8;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [JUMP_W-1:0]  LIGHT_JUMP_RST  = 18'd300;
    localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST = 16'd200;
    localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 16'd20000;
    localparam logic [TICK_W-1:0]  BUZZ_TICKS_RST  = 8'd8;
    localparam logic [TICK_W-1:0]  WAIT_TICKS_RST  = 8'd16;

    typedef struct packed {
        logic [JUMP_W-1:0]  light_jump;
        logic [LIMIT_W-1:0] accel_limit;
        logic [LIMIT_W-1:0] gyro_limit;
        logic [TICK_W-1:0]  buzz_ticks;
        logic [TICK_W-1:0]  wait_ticks;
    } cfg_t;

    // classification of one sample as the front hands it to the back
    typedef struct packed {
        logic motion;
        logic light_ok;
    } sample_flags_t;

endpackage

>>> rtl/core/mlas_front.sv
module mlas_front #(
    parameter int MOTION_WIDTH = 16,
    parameter int LIGHT_WIDTH  = 24,
    localparam int LL_W        = LIGHT_WIDTH - 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [LIGHT_WIDTH-1:0]            light_raw,
    input  logic                              light_ok,
    input  logic [2:0][MOTION_WIDTH-1:0]      accel,
    input  logic [2:0][MOTION_WIDTH-1:0]      gyro,
    input  mlas_pkg::cfg_t                    cfg,
    output logic                              out_valid,
    output mlas_pkg::sample_flags_t           out_flags,
    output logic [LL_W-1:0]                   out_light,
    output logic [1:0]                        busy_cnt
);

    // x / 100 as (x * ceil(2^SHIFT / 100)) >> SHIFT, exact for LIGHT_WIDTH-bit x
    localparam int SHIFT  = LIGHT_WIDTH + 7;
    localparam int PROD_W = 2 * LIGHT_WIDTH + 1;
    localparam logic [LIGHT_WIDTH:0] RECIP = (LIGHT_WIDTH + 1)'(
        ((64'd1 << SHIFT) + 64'(mlas_pkg::LUX_DIV) - 64'd1) / 64'(mlas_pkg::LUX_DIV));
    localparam int SQ_W  = 2 * MOTION_WIDTH;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > mlas_pkg::LIMIT_SQ_W) ? SUM_W : mlas_pkg::LIMIT_SQ_W;
    localparam int LIM1_W = mlas_pkg::LIMIT_W + 1;

    logic [mlas_pkg::LIMIT_SQ_W-1:0] accel_sq_reg, gyro_sq_reg;
    logic [LIM1_W-1:0]               accel_lim1, gyro_lim1;

    logic                            s1_v_reg, s2_v_reg, s3_v_reg;
    logic [2:0][MOTION_WIDTH-1:0]    s1_acc_reg, s1_gyr_reg;
    logic [PROD_W-1:0]               s1_prod_reg;
    logic                            s1_ok_reg, s2_ok_reg;
    logic [2:0][SQ_W-1:0]            s2_acc_reg, s2_gyr_reg;
    logic [LL_W-1:0]                 s2_light_reg, s3_light_reg;
    mlas_pkg::sample_flags_t         s3_flags_reg;

    logic [2:0][MOTION_WIDTH-1:0]    acc_abs, gyr_abs;
    logic [PROD_W-1:0]               prod;
    logic [2:0][SQ_W-1:0]            acc_sq, gyr_sq;
    logic [SUM_W-1:0]                acc_sum, gyr_sum;
    logic                            motion_hit;

    // limit squares are registered from the config registers and follow them in the next cycle
    assign accel_lim1 = LIM1_W'(cfg.accel_limit) + LIM1_W'(1);
    assign gyro_lim1  = LIM1_W'(cfg.gyro_limit) + LIM1_W'(1);

    always_ff @(posedge aclk) begin
        accel_sq_reg <= mlas_pkg::LIMIT_SQ_W'(accel_lim1) * mlas_pkg::LIMIT_SQ_W'(accel_lim1);
        gyro_sq_reg  <= mlas_pkg::LIMIT_SQ_W'(gyro_lim1) * mlas_pkg::LIMIT_SQ_W'(gyro_lim1);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_abs[i] = accel[i][MOTION_WIDTH-1] ? (~accel[i] + 1'b1) : accel[i];
            gyr_abs[i] = gyro[i][MOTION_WIDTH-1]  ? (~gyro[i] + 1'b1)  : gyro[i];
        end
        for (int i = 0; i < 3; i++) begin
            acc_sq[i] = SQ_W'(s1_acc_reg[i]) * SQ_W'(s1_acc_reg[i]);
            gyr_sq[i] = SQ_W'(s1_gyr_reg[i]) * SQ_W'(s1_gyr_reg[i]);
        end
    end

    assign prod = PROD_W'(light_raw) * PROD_W'(RECIP);

    assign acc_sum = SUM_W'(s2_acc_reg[0]) + SUM_W'(s2_acc_reg[1]) + SUM_W'(s2_acc_reg[2]);
    assign gyr_sum = SUM_W'(s2_gyr_reg[0]) + SUM_W'(s2_gyr_reg[1]) + SUM_W'(s2_gyr_reg[2]);
    assign motion_hit = (CMP_W'(acc_sum) >= CMP_W'(accel_sq_reg)) ||
                        (CMP_W'(gyr_sum) >= CMP_W'(gyro_sq_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_acc_reg   <= acc_abs;
        s1_gyr_reg   <= gyr_abs;
        s1_prod_reg  <= prod;
        s1_ok_reg    <= light_ok;
        s2_acc_reg   <= acc_sq;
        s2_gyr_reg   <= gyr_sq;
        s2_light_reg <= s1_prod_reg[SHIFT +: LL_W];
        s2_ok_reg    <= s1_ok_reg;
        s3_light_reg <= s2_light_reg;
        s3_flags_reg.motion   <= motion_hit;
        s3_flags_reg.light_ok <= s2_ok_reg;
    end

    assign out_valid = s3_v_reg;
    assign out_flags = s3_flags_reg;
    assign out_light = s3_light_reg;
    assign busy_cnt  = 2'(s1_v_reg) + 2'(s2_v_reg) + 2'(s3_v_reg);

endmodule

>>> rtl/core/mlas_fifo.sv
module mlas_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic [AW:0]      count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg, count_next;

    assign count_next = count_reg + (AW + 1)'(push) - (AW + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

>>> rtl/core/mlas_back.sv
module mlas_back #(
    parameter int LL_W = 18
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  mlas_pkg::sample_flags_t in_flags,
    input  logic [LL_W-1:0]         in_light,
    output logic                    in_ready,
    input  mlas_pkg::cfg_t          cfg,
    output logic                    m_valid,
    output mlas_pkg::mode_t         m_mode,
    output logic                    m_buzz,
    input  logic                    m_ready
);

    localparam int DW = (LL_W > mlas_pkg::JUMP_W) ? LL_W : mlas_pkg::JUMP_W;

    mlas_pkg::mode_t              mode_reg, mode_next;
    logic [LL_W-1:0]              last_reg, last_next;
    logic                         known_reg, known_next;
    logic                         change_reg, change_next;
    logic [mlas_pkg::TICK_W-1:0]  ticks_reg, ticks_next;
    logic                         m_valid_reg;
    mlas_pkg::mode_t              m_mode_reg;
    logic                         m_buzz_reg;

    logic                         pop;
    logic [LL_W-1:0]              diff;
    logic                         jump;
    logic                         done;

    assign pop  = in_valid && (!m_valid_reg || m_ready);
    assign diff = (in_light >= last_reg) ? (in_light - last_reg) : (last_reg - in_light);
    assign jump = in_flags.light_ok && known_reg && (DW'(diff) >= DW'(cfg.light_jump));
    // zero ticks behaves as one
    assign done = (ticks_reg <= mlas_pkg::TICK_W'(1));

    always_comb begin
        mode_next   = mode_reg;
        last_next   = last_reg;
        known_next  = known_reg;
        change_next = change_reg;
        ticks_next  = ticks_reg;
        if (mode_reg != mlas_pkg::MODE_IDLE && in_flags.light_ok) begin
            last_next  = in_light;
            known_next = 1'b1;
        end
        case (mode_reg)
            mlas_pkg::MODE_IDLE: begin
                if (in_flags.motion) begin
                    mode_next  = mlas_pkg::MODE_INTERIM;
                    known_next = 1'b0;
                end
            end
            mlas_pkg::MODE_INTERIM: begin
                if (jump) begin
                    change_next = 1'b0;
                    known_next  = 1'b0;
                    mode_next   = mlas_pkg::MODE_BUZZ;
                    ticks_next  = cfg.buzz_ticks;
                end
            end
            mlas_pkg::MODE_BUZZ: begin
                if (jump) begin
                    change_next = 1'b1;
                end
                if (done) begin
                    ticks_next = '0;
                    if (change_reg || jump) begin
                        // back to idle, and this sample is checked for motion too
                        if (in_flags.motion) begin
                            mode_next  = mlas_pkg::MODE_INTERIM;
                            known_next = 1'b0;
                        end else begin
                            mode_next = mlas_pkg::MODE_IDLE;
                        end
                    end else begin
                        mode_next  = mlas_pkg::MODE_WAIT;
                        ticks_next = cfg.wait_ticks;
                    end
                end else begin
                    ticks_next = ticks_reg - 1'b1;
                end
            end
            mlas_pkg::MODE_WAIT: begin
                if (jump) begin
                    change_next = 1'b1;
                end
                if (done) begin
                    mode_next  = mlas_pkg::MODE_BUZZ;
                    ticks_next = cfg.buzz_ticks;
                end else begin
                    ticks_next = ticks_reg - 1'b1;
                end
            end
            default: begin
                mode_next = mlas_pkg::MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= mlas_pkg::MODE_IDLE;
            last_reg    <= '0;
            known_reg   <= 1'b0;
            change_reg  <= 1'b0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg   <= mode_next;
                last_reg   <= last_next;
                known_reg  <= known_next;
                change_reg <= change_next;
                ticks_reg  <= ticks_next;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_mode_reg <= mode_next;
            m_buzz_reg <= (mode_next == mlas_pkg::MODE_BUZZ);
        end
    end

    assign in_ready = pop;
    assign m_valid  = m_valid_reg;
    assign m_mode   = m_mode_reg;
    assign m_buzz   = m_buzz_reg;

endmodule

>>> rtl/core/motion_light_alarm_sequencer.sv
// An accepted input word passes the 3 classify stages, the queue and the output register
// on its way to m_axis, and is held there while m_axis is stalled.
// Throughput: one word per cycle while s_axis_tready is high; the multipliers of the
// classify pipeline are fully pipelined and the mode update is combinational logic.
// s_axis_tready drops once queue plus classify stages hold 8 words.
// Reset (aresetn low, synchronous): mode idle, light history cleared, config to defaults.
module motion_light_alarm_sequencer #(
    parameter int MOTION_WIDTH = 16,
    parameter int LIGHT_WIDTH  = 24,
    localparam int IN_W        = LIGHT_WIDTH + 1 + 6 * MOTION_WIDTH,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // light_raw, light_ok, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mode_now[1:0], buzzer_on
    output logic [mlas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mlas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlas_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LL_W  = LIGHT_WIDTH - 6;
    localparam int Q_W   = LL_W + $bits(mlas_pkg::sample_flags_t);
    localparam int Q_AW  = $clog2(mlas_pkg::QUEUE_DEPTH);
    localparam int ACC_LO = LIGHT_WIDTH + 1;
    localparam int GYR_LO = ACC_LO + 3 * MOTION_WIDTH;

    mlas_pkg::cfg_t            cfg_reg;
    logic                      s_fire;
    logic                      f_valid;
    mlas_pkg::sample_flags_t   f_flags;
    logic [LL_W-1:0]           f_light;
    logic [1:0]                busy_cnt;
    logic [Q_W-1:0]            q_out;
    logic                      q_not_empty;
    logic                      q_pop;
    logic [Q_AW:0]             q_count;
    logic [Q_AW:0]             q_used;
    mlas_pkg::mode_t           b_mode;
    logic                      b_buzz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.light_jump  <= mlas_pkg::LIGHT_JUMP_RST;
            cfg_reg.accel_limit <= mlas_pkg::ACCEL_LIMIT_RST;
            cfg_reg.gyro_limit  <= mlas_pkg::GYRO_LIMIT_RST;
            cfg_reg.buzz_ticks  <= mlas_pkg::BUZZ_TICKS_RST;
            cfg_reg.wait_ticks  <= mlas_pkg::WAIT_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                mlas_pkg::CFG_LIGHT_JUMP:  cfg_reg.light_jump  <= cfg_data;
                mlas_pkg::CFG_ACCEL_LIMIT: cfg_reg.accel_limit <= cfg_data[mlas_pkg::LIMIT_W-1:0];
                mlas_pkg::CFG_GYRO_LIMIT:  cfg_reg.gyro_limit  <= cfg_data[mlas_pkg::LIMIT_W-1:0];
                mlas_pkg::CFG_BUZZ_TICKS:  cfg_reg.buzz_ticks  <= cfg_data[mlas_pkg::TICK_W-1:0];
                mlas_pkg::CFG_WAIT_TICKS:  cfg_reg.wait_ticks  <= cfg_data[mlas_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // credit: every word in the classify stages already owns a queue slot
    assign q_used        = q_count + (Q_AW + 1)'(busy_cnt);
    assign s_axis_tready = (q_used < (Q_AW + 1)'(mlas_pkg::QUEUE_DEPTH));
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    mlas_front #(
        .MOTION_WIDTH (MOTION_WIDTH),
        .LIGHT_WIDTH  (LIGHT_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_fire),
        .light_raw (s_axis_tdata[LIGHT_WIDTH-1:0]),
        .light_ok  (s_axis_tdata[LIGHT_WIDTH]),
        .accel     (s_axis_tdata[ACC_LO +: 3 * MOTION_WIDTH]),
        .gyro      (s_axis_tdata[GYR_LO +: 3 * MOTION_WIDTH]),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_flags (f_flags),
        .out_light (f_light),
        .busy_cnt  (busy_cnt)
    );

    mlas_fifo #(
        .WIDTH (Q_W),
        .DEPTH (mlas_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid),
        .push_data ({f_flags, f_light}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    mlas_back #(
        .LL_W (LL_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_not_empty),
        .in_flags (q_out[LL_W +: $bits(mlas_pkg::sample_flags_t)]),
        .in_light (q_out[LL_W-1:0]),
        .in_ready (q_pop),
        .cfg      (cfg_reg),
        .m_valid  (m_axis_tvalid),
        .m_mode   (b_mode),
        .m_buzz   (b_buzz),
        .m_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {(mlas_pkg::OUT_TDATA_W - 3)'(0), b_buzz, b_mode};

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_used <= (Q_AW + 1)'(mlas_pkg::QUEUE_DEPTH))
        else $error("queue credit exceeded");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_count != '0))
        else $error("pop from empty queue");

    a_buzz_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == mlas_pkg::MODE_BUZZ)))
        else $error("buzzer flag disagrees with mode");

    a_fill_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !q_pop) |=> (q_count != '0))
        else $error("queue lost a word");
`endif

endmodule

>>> test/tb_motion_light_alarm_sequencer.sv
`timescale 1ns / 100ps

module tb_motion_light_alarm_sequencer;
    import mlas_pkg::*;

    localparam int IN_TDATA_W  = 128;
    localparam int LUX_MAX     = 167772;
    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic [23:0]        light_raw;
        logic               light_ok;
        logic signed [15:0] accel_x, accel_y, accel_z;
        logic signed [15:0] gyro_x, gyro_y, gyro_z;
    } sample_t;

    typedef struct {
        mode_t mode_now;
        logic  buzzer_on;
    } mode_word_t;

    // Tracks the alarm mode per sample and checks each output word against it.
    class alarm_mode_board;
        logic [JUMP_W-1:0]  light_jump;
        logic [LIMIT_W-1:0] accel_limit, gyro_limit;
        logic [TICK_W-1:0]  buzz_ticks, wait_ticks;
        mode_t              mode;
        int unsigned        last_lux;
        bit                 lux_known, change_seen;
        int unsigned        ticks_left;
        mode_word_t         expected[$];
        int                 errors;

        function new();
            light_jump  = LIGHT_JUMP_RST;
            accel_limit = ACCEL_LIMIT_RST;
            gyro_limit  = GYRO_LIMIT_RST;
            buzz_ticks  = BUZZ_TICKS_RST;
            wait_ticks  = WAIT_TICKS_RST;
            mode        = MODE_IDLE;
            last_lux    = 0;
            lux_known   = 0;
            change_seen = 0;
            ticks_left  = 0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LIGHT_JUMP:  light_jump  = val[JUMP_W-1:0];
                CFG_ACCEL_LIMIT: accel_limit = val[LIMIT_W-1:0];
                CFG_GYRO_LIMIT:  gyro_limit  = val[LIMIT_W-1:0];
                CFG_BUZZ_TICKS:  buzz_ticks  = val[TICK_W-1:0];
                CFG_WAIT_TICKS:  wait_ticks  = val[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sum_sq(logic signed [15:0] a, logic signed [15:0] b,
                                logic signed [15:0] c);
            longint x, y, z;
            x = a;
            y = b;
            z = c;
            return x * x + y * y + z * z;
        endfunction

        // floor(sqrt(s)) > L  <=>  s >= (L+1)^2
        function void idle_step(sample_t smp);
            longint al, gl;
            al = longint'(accel_limit) + 1;
            gl = longint'(gyro_limit) + 1;
            if (sum_sq(smp.accel_x, smp.accel_y, smp.accel_z) >= al * al ||
                sum_sq(smp.gyro_x, smp.gyro_y, smp.gyro_z) >= gl * gl) begin
                mode      = MODE_INTERIM;
                lux_known = 0;
            end else begin
                mode = MODE_IDLE;
            end
        endfunction

        // returns 1 on a jump from a known previous reading
        function bit light_step(sample_t smp);
            int unsigned lux, diff;
            bit jmp;
            jmp = 0;
            if (!smp.light_ok)
                return 0;
            lux = smp.light_raw / LUX_DIV;
            if (lux_known) begin
                diff = (lux >= last_lux) ? lux - last_lux : last_lux - lux;
                jmp  = diff >= light_jump;
            end
            last_lux  = lux;
            lux_known = 1;
            return jmp;
        endfunction

        function bit tick_done();
            if (ticks_left <= 1) begin
                ticks_left = 0;
                return 1;
            end
            ticks_left--;
            return 0;
        endfunction

        function void take_sample(sample_t smp);
            mode_word_t w;
            case (mode)
                MODE_IDLE: idle_step(smp);
                MODE_INTERIM: begin
                    if (light_step(smp)) begin
                        change_seen = 0;
                        lux_known   = 0;
                        mode        = MODE_BUZZ;
                        ticks_left  = buzz_ticks;
                    end
                end
                MODE_BUZZ: begin
                    if (light_step(smp))
                        change_seen = 1;
                    if (tick_done()) begin
                        if (change_seen) begin
                            idle_step(smp);
                        end else begin
                            mode       = MODE_WAIT;
                            ticks_left = wait_ticks;
                        end
                    end
                end
                default: begin
                    if (light_step(smp))
                        change_seen = 1;
                    if (tick_done()) begin
                        mode       = MODE_BUZZ;
                        ticks_left = buzz_ticks;
                    end
                end
            endcase
            w.mode_now  = mode;
            w.buzzer_on = (mode == MODE_BUZZ);
            expected.push_back(w);
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] d);
            mode_word_t want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: unexpected word, actual mode=%0d buzzer=%0b",
                             $time, d[1:0], d[2]);
                return;
            end
            want = expected.pop_front();
            if (d[1:0] !== want.mode_now) begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: mode_now expected %0d actual %0d",
                             $time, want.mode_now, d[1:0]);
            end
            if (d[2] !== want.buzzer_on) begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: buzzer_on expected %0b actual %0b",
                             $time, want.buzzer_on, d[2]);
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    alarm_mode_board board;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  lux_cursor    = 0;
    int  stall_count   = 0;

    motion_light_alarm_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic sample_t mk(int raw, int ok, int ax, int ay, int az,
                                   int gx, int gy, int gz);
        sample_t smp;
        smp.light_raw = raw;
        smp.light_ok  = ok;
        smp.accel_x   = ax;
        smp.accel_y   = ay;
        smp.accel_z   = az;
        smp.gyro_x    = gx;
        smp.gyro_y    = gy;
        smp.gyro_z    = gz;
        return smp;
    endfunction

    function automatic logic signed [15:0] draw_axis(int peak);
        int v;
        v = $urandom_range(peak, 0);
        return $urandom_range(1) ? -v : v;
    endfunction

    // mostly quiet motion with occasional triggers, light walking around the jump size
    function automatic sample_t draw_sample();
        sample_t smp;
        int ap, gp, trig, lux, stride, raw;
        if ($urandom_range(99) < 8) begin
            smp.light_raw = $urandom();
            smp.light_ok  = $urandom_range(1);
            smp.accel_x   = $urandom();
            smp.accel_y   = $urandom();
            smp.accel_z   = $urandom();
            smp.gyro_x    = $urandom();
            smp.gyro_y    = $urandom();
            smp.gyro_z    = $urandom();
            return smp;
        end
        ap = board.accel_limit / 2;
        gp = board.gyro_limit / 2;
        if (ap > 32767) ap = 32767;
        if (gp > 32767) gp = 32767;
        smp.accel_x = draw_axis(ap);
        smp.accel_y = draw_axis(ap);
        smp.accel_z = draw_axis(ap);
        smp.gyro_x  = draw_axis(gp);
        smp.gyro_y  = draw_axis(gp);
        smp.gyro_z  = draw_axis(gp);
        if ($urandom_range(99) < ((board.mode == MODE_IDLE) ? 35 : 12)) begin
            if ($urandom_range(1))
                trig = int'(board.accel_limit) + 1 + $urandom_range(40);
            else
                trig = int'(board.gyro_limit) + 1 + $urandom_range(40);
            if (trig > 32767) trig = 32767;
            if ($urandom_range(1)) trig = -trig;
            case ($urandom_range(5))
                0: smp.accel_x = trig;
                1: smp.accel_y = trig;
                2: smp.accel_z = trig;
                3: smp.gyro_x  = trig;
                4: smp.gyro_y  = trig;
                default: smp.gyro_z = trig;
            endcase
        end
        smp.light_ok = ($urandom_range(99) >= 10);
        if ($urandom_range(99) < 40)
            stride = int'(board.light_jump) + $urandom_range(20);
        else
            stride = $urandom_range(board.light_jump / 2);
        lux = $urandom_range(1) ? lux_cursor + stride : lux_cursor - stride;
        if (lux < 0) lux = lux_cursor + stride;
        if (lux > LUX_MAX) lux = lux_cursor - stride;
        if (lux < 0) lux = 0;
        if (lux > LUX_MAX) lux = LUX_MAX;
        lux_cursor = lux;
        raw = lux * 100 + $urandom_range(99);
        if (raw > 24'hFFFFFF) raw = 24'hFFFFFF;
        smp.light_raw = raw;
        return smp;
    endfunction

    task automatic send_sample(sample_t smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {7'b0, smp.gyro_z, smp.gyro_y, smp.gyro_x,
                          smp.accel_z, smp.accel_y, smp.accel_x,
                          smp.light_ok, smp.light_raw};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        board.take_sample(smp);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [5]);
        for (int i = 0; i < 5; i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            board.set_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.expected.size() != 0)
            @(posedge aclk);
    endtask

    // receiver: random stalls plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = 80;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.check_word(m_axis_tdata);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] regs [5];
        int phase_len;
        board = new();
        aresetn       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 81;
        regs[CFG_LIGHT_JUMP]  = 300;
        regs[CFG_ACCEL_LIMIT] = 200;
        regs[CFG_GYRO_LIMIT]  = 20000;
        regs[CFG_BUZZ_TICKS]  = 2;
        regs[CFG_WAIT_TICKS]  = 1;
        program_regs(regs);

        // directed walk through every mode and boundary
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 1, 200, 0, 0, 0, 0, 0));              // magnitude at limit: quiet
        send_sample(mk(0, 1, 201, 0, 0, 0, 0, 0));              // just over: interim
        send_sample(mk(24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0));       // bad light ignored
        send_sample(mk(100000, 1, 0, 0, 0, 0, 0, 0));           // first light, stored
        send_sample(mk(129999, 1, 0, 0, 0, 0, 0, 0));           // 299 lux change: no jump
        send_sample(mk(159900, 1, 0, 0, 0, 0, 0, 0));           // 300 lux change: buzz
        send_sample(mk(24'hFFFFFF, 1, 0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 1, 0, 0, 0, -32768, -32768, -32768)); // buzz end, motion same word
        send_sample(mk(0, 1, 0, 0, 0, 0, 0, 0));
        send_sample(mk(30000, 1, 0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));                // no change: wait
        send_sample(mk(50000, 1, 0, 0, 0, 0, 0, 0));
        send_sample(mk(80000, 1, 0, 0, 0, 0, 0, 0));
        send_sample(mk(80000, 1, -5, 7, 3, 10, -10, 5));        // change seen: back to idle
        send_sample(mk(0, 1, 0, 0, 0, 0, 0, 20000));
        send_sample(mk(0, 1, 0, 0, 0, -20001, 0, 0));
        send_sample(mk(99, 1, -32768, -32768, -32768, 0, 0, 0));
        send_sample(mk(199, 1, 32767, 32767, 32767, 32767, 32767, 32767));
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            phase_len = 90;
            case (ph)
                0: begin
                    regs[CFG_LIGHT_JUMP]  = LIGHT_JUMP_RST;
                    regs[CFG_ACCEL_LIMIT] = ACCEL_LIMIT_RST;
                    regs[CFG_GYRO_LIMIT]  = GYRO_LIMIT_RST;
                    regs[CFG_BUZZ_TICKS]  = BUZZ_TICKS_RST;
                    regs[CFG_WAIT_TICKS]  = WAIT_TICKS_RST;
                end
                1: begin
                    regs[CFG_LIGHT_JUMP]  = 0;
                    regs[CFG_ACCEL_LIMIT] = 0;
                    regs[CFG_GYRO_LIMIT]  = 0;
                    regs[CFG_BUZZ_TICKS]  = 0;
                    regs[CFG_WAIT_TICKS]  = 0;
                end
                2: begin
                    regs[CFG_LIGHT_JUMP]  = 18'h3FFFF;
                    regs[CFG_ACCEL_LIMIT] = 16'hFFFF;
                    regs[CFG_GYRO_LIMIT]  = 16'hFFFF;
                    regs[CFG_BUZZ_TICKS]  = 8'hFF;
                    regs[CFG_WAIT_TICKS]  = 8'hFF;
                    phase_len = 30;
                end
                3: begin
                    regs[CFG_LIGHT_JUMP]  = 50;
                    regs[CFG_ACCEL_LIMIT] = 100;
                    regs[CFG_GYRO_LIMIT]  = 1000;
                    regs[CFG_BUZZ_TICKS]  = 1;
                    regs[CFG_WAIT_TICKS]  = 3;
                end
                4: begin
                    regs[CFG_LIGHT_JUMP]  = $urandom_range(600);
                    regs[CFG_ACCEL_LIMIT] = $urandom_range(400, 50);
                    regs[CFG_GYRO_LIMIT]  = $urandom_range(8000, 100);
                    regs[CFG_BUZZ_TICKS]  = $urandom_range(6, 1);
                    regs[CFG_WAIT_TICKS]  = $urandom_range(6, 1);
                end
                default: begin
                    regs[CFG_LIGHT_JUMP]  = 1000;
                    regs[CFG_ACCEL_LIMIT] = 300;
                    regs[CFG_GYRO_LIMIT]  = 5000;
                    regs[CFG_BUZZ_TICKS]  = 3;
                    regs[CFG_WAIT_TICKS]  = 2;
                end
            endcase
            case (ph / 2)
                0: begin send_idle_pct = 27; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            drain();
            program_regs(regs);
            // long output stall while words keep coming, fills the queue
            if (ph == 4)
                hold_request = 1'b1;
            repeat (phase_len)
                send_sample(draw_sample());
            s_axis_tvalid <= 1'b0;
        end

        drain();
        repeat (12) @(posedge aclk);
        if (board.errors == 0 && board.expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/mlas_pkg.sv
rtl/core/mlas_front.sv
rtl/core/mlas_fifo.sv
rtl/core/mlas_back.sv
rtl/core/motion_light_alarm_sequencer.sv
test/tb_motion_light_alarm_sequencer.sv
